@@ src/mbs_pkg.sv @@
package mbs_pkg;

    localparam int CH_W       = 16;
    localparam int PIX_W      = 3 * CH_W;
    localparam int SUM_W      = 20;
    localparam int N_W        = 4;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = 5;
    localparam int J_W        = 3;
    localparam int DRD_READS  = 6;
    localparam int SIDE_W     = 11;
    localparam int MASK_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_UP2,
        S_RD_UP1,
        S_LOAD,
        S_DRD,
        S_SUM,
        S_DIV,
        S_OUT,
        S_ADV
    } t_state;

    typedef enum logic [1:0] {
        V_MAIN,
        V_EDGE,
        V_DRAIN
    } t_view;

    typedef struct packed {
        logic  latch_pix;
        logic  rd_up2;
        logic  rd_up1;
        logic  load_win;
        logic  drd_clr;
        logic  drd_step;
        logic  sum;
        logic  div_step;
        logic  load_out;
        logic  advance;
        t_view view;
    } t_cmd;

    typedef struct packed {
        logic pix_ok;
        logic drain_ok;
        logic need_a;
        logic need_b;
        logic drd_done;
        logic div_last;
        logic out_full;
    } t_status;

endpackage

@@ src/mbs_if.sv @@
interface mbs_pix_if import mbs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source(output valid, op, red_in, green_in, blue_in, input ready);
    modport sink(input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface mbs_res_if import mbs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_of_frame;
    logic            empty_window;

    modport source(output valid, red_out, green_out, blue_out, last_of_frame, empty_window,
                   input ready);
    modport sink(input valid, red_out, green_out, blue_out, last_of_frame, empty_window,
                 output ready);
endinterface

interface mbs_cfg_if import mbs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ src/mbs_ctrl.sv @@
module mbs_ctrl import mbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_view  r_view, n_view;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_view  <= V_MAIN;
        end else begin
            r_state <= n_state;
            r_view  <= n_view;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_view     = r_view;
        o_cmd      = '0;
        o_cmd.view = r_view;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_PIXEL && i_status.pix_ok) begin
                        o_cmd.latch_pix = 1'b1;
                        n_view          = V_MAIN;
                        n_state         = S_RD_UP2;
                    end else if (i_op == OP_DRAIN && i_status.drain_ok) begin
                        o_cmd.drd_clr = 1'b1;
                        n_view        = V_DRAIN;
                        n_state       = S_DRD;
                    end
                end
            end
            S_RD_UP2: begin
                o_cmd.rd_up2 = 1'b1;
                n_state      = S_RD_UP1;
            end
            S_RD_UP1: begin
                o_cmd.rd_up1 = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_win = 1'b1;
                if (i_status.need_a) begin
                    n_state = S_SUM;
                end else if (i_status.need_b) begin
                    n_view  = V_EDGE;
                    n_state = S_SUM;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_DRD: begin
                o_cmd.drd_step = 1'b1;
                if (i_status.drd_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    if (r_view == V_MAIN && i_status.need_b) begin
                        n_view  = V_EDGE;
                        n_state = S_SUM;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/mbs_datapath.sv @@
module mbs_datapath import mbs_pkg::*; #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CH_W-1:0]       o_red,
    output logic [CH_W-1:0]       o_green,
    output logic [CH_W-1:0]       o_blue,
    output logic                  o_last,
    output logic                  o_empty
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW = CW + 1;

    logic [SIDE_W-1:0] r_side;
    logic [MASK_W-1:0] r_mask;
    logic [SW-1:0]     r_row, r_col, r_k;
    logic [SW-1:0]     eff;

    logic [PIX_W-1:0]  mem [2**AW];
    logic [PIX_W-1:0]  r_rd_data;
    logic [PIX_W-1:0]  r_pix, r_up2;
    logic [PIX_W-1:0]  r_win [3][3];
    logic [J_W-1:0]    r_j;

    logic [SUM_W-1:0]  r_qd [3];
    logic [N_W-1:0]    r_rem [3];
    logic [N_W-1:0]    r_n;
    logic              r_dempty, r_dlast;
    logic [STEP_W-1:0] r_step;

    logic              r_ov;
    logic [CH_W-1:0]   r_ored, r_ogreen, r_oblue;
    logic              r_olast, r_oempty;

    logic              re;
    logic [AW-1:0]     raddr, waddr;
    logic [1:0]        db;
    logic              drow;
    logic [2:0]        rv, cv;
    logic [MASK_W-1:0] en;
    logic [SUM_W-1:0]  s_sum [3];
    logic [N_W-1:0]    s_n;
    logic              s_last;

    always_comb begin
        if (r_side == '0) begin
            eff = SW'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            eff = SW'(MAX_SIDE);
        end else begin
            eff = SW'(r_side);
        end
    end

    assign o_status.pix_ok   = (r_row < eff) && (r_col < eff);
    assign o_status.drain_ok = (r_row == eff) && (r_k < eff);
    assign o_status.need_a   = (r_row != '0) && (r_col != '0);
    assign o_status.need_b   = (r_row != '0) && (r_col == eff - SW'(1));
    assign o_status.drd_done = (r_j == J_W'(DRD_READS));
    assign o_status.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.out_full = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(1);
            r_mask <= '1;
            r_row  <= '0;
            r_col  <= '0;
            r_k    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SIDE) begin
                r_side <= i_cfg_data;
                r_row  <= '0;
                r_col  <= '0;
                r_k    <= '0;
            end else begin
                r_mask <= i_cfg_data[MASK_W-1:0];
            end
        end else if (i_cmd.advance) begin
            if (i_cmd.view == V_DRAIN) begin
                if (r_k + SW'(1) >= eff) begin
                    r_k   <= '0;
                    r_row <= '0;
                    r_col <= '0;
                end else begin
                    r_k <= r_k + SW'(1);
                end
            end else if (r_col + SW'(1) >= eff) begin
                r_col <= '0;
                r_row <= r_row + SW'(1);
            end else begin
                r_col <= r_col + SW'(1);
            end
        end
    end

    always_comb begin
        if (r_j < J_W'(3)) begin
            db   = r_j[1:0];
            drow = eff[0];
        end else begin
            db   = 2'(r_j - J_W'(3));
            drow = ~eff[0];
        end
        re    = i_cmd.rd_up2 || i_cmd.rd_up1 || (i_cmd.drd_step && r_j < J_W'(DRD_READS));
        waddr = {r_row[0], r_col[CW-1:0]};
        if (i_cmd.rd_up2) begin
            raddr = {r_row[0], r_col[CW-1:0]};
        end else if (i_cmd.rd_up1) begin
            raddr = {~r_row[0], r_col[CW-1:0]};
        end else begin
            raddr = {drow, r_k[CW-1:0] + CW'(db) - CW'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win) begin
            mem[waddr] <= r_pix;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pix) begin
            r_pix <= {i_red, i_green, i_blue};
        end
        if (i_cmd.rd_up1) begin
            r_up2 <= r_rd_data;
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if (i_cmd.load_win) begin
                    if (b < 2) begin
                        r_win[a][b] <= r_win[a][b+1];
                    end
                end else if (i_cmd.drd_step && r_j != '0
                             && (r_j - J_W'(1)) == J_W'(a * 3 + b)) begin
                    r_win[a][b] <= r_rd_data;
                end
            end
        end
        if (i_cmd.load_win) begin
            r_win[0][2] <= r_up2;
            r_win[1][2] <= r_rd_data;
            r_win[2][2] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else if (i_cmd.drd_clr) begin
            r_j <= '0;
        end else if (i_cmd.drd_step) begin
            r_j <= r_j + J_W'(1);
        end
    end

    always_comb begin
        logic [PIX_W-1:0] v;
        unique case (i_cmd.view)
            V_MAIN: begin
                rv = {1'b1, 1'b1, r_row >= SW'(2)};
                cv = {1'b1, 1'b1, r_col >= SW'(2)};
            end
            V_EDGE: begin
                rv = {1'b1, 1'b1, r_row >= SW'(2)};
                cv = {1'b0, 1'b1, r_col != '0};
            end
            V_DRAIN: begin
                rv = {1'b0, 1'b1, eff >= SW'(2)};
                cv = {(r_k + SW'(1)) < eff, 1'b1, r_k != '0};
            end
            default: begin
                rv = '0;
                cv = '0;
            end
        endcase
        s_sum[0] = '0;
        s_sum[1] = '0;
        s_sum[2] = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                en[a*3+b] = rv[a] && cv[b] && r_mask[a*3+b];
                if (i_cmd.view == V_EDGE && b < 2) begin
                    v = r_win[a][(b < 2) ? b + 1 : b];
                end else begin
                    v = r_win[a][b];
                end
                if (en[a*3+b]) begin
                    s_sum[0] = s_sum[0] + SUM_W'(v[3*CH_W-1:2*CH_W]);
                    s_sum[1] = s_sum[1] + SUM_W'(v[2*CH_W-1:CH_W]);
                    s_sum[2] = s_sum[2] + SUM_W'(v[CH_W-1:0]);
                end
            end
        end
        s_n    = N_W'($countones(en));
        s_last = (i_cmd.view == V_DRAIN) && (r_k == eff - SW'(1));
    end

    always_ff @(posedge i_clk) begin
        logic [N_W:0] t;
        if (i_cmd.sum) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_qd[ch]  <= s_sum[ch];
                r_rem[ch] <= '0;
            end
            r_n      <= s_n;
            r_dempty <= (s_n == '0);
            r_dlast  <= s_last;
            r_step   <= '0;
        end else if (i_cmd.div_step) begin
            for (int ch = 0; ch < 3; ch++) begin
                t = {r_rem[ch], r_qd[ch][SUM_W-1]};
                if (t >= {1'b0, r_n}) begin
                    r_rem[ch] <= N_W'(t - {1'b0, r_n});
                    r_qd[ch]  <= {r_qd[ch][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= t[N_W-1:0];
                    r_qd[ch]  <= {r_qd[ch][SUM_W-2:0], 1'b0};
                end
            end
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ored   <= r_dempty ? '0 : r_qd[0][CH_W-1:0];
            r_ogreen <= r_dempty ? '0 : r_qd[1][CH_W-1:0];
            r_oblue  <= r_dempty ? '0 : r_qd[2][CH_W-1:0];
            r_olast  <= r_dlast;
            r_oempty <= r_dempty;
        end
    end

    assign o_out_valid = r_ov;
    assign o_red       = r_ored;
    assign o_green     = r_ogreen;
    assign o_blue      = r_oblue;
    assign o_last      = r_olast;
    assign o_empty     = r_oempty;

endmodule

@@ src/masked_box_smooth_3x3_unit.sv @@
// channel  dir  handshake      word
// i_pix    in   valid/ready    op, red_in, green_in, blue_in
// o_res    out  valid/ready    red_out, green_out, blue_out, last_of_frame, empty_window
// i_cfg    in   valid/ready    index (0 side_length, 1 window_mask), data
//
// A pixel word yields no result, one or two results; a drain word yields one; an ignored
// word yields none. A new word is accepted only once the last is done. Each result runs a
// 20-step bit-serial divider; the line store reads one entry per cycle. Reset is
// synchronous on i_rst_n. A full output register stalls the controller before the next
// result is loaded.
module masked_box_smooth_3x3_unit import mbs_pkg::*; #(
    parameter int MAX_SIDE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbs_pix_if.sink     i_pix,
    mbs_res_if.source   o_res,
    mbs_cfg_if.sink     i_cfg
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_pix.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    mbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_op       (i_pix.op),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbs_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_red       (o_res.red_out),
        .o_green     (o_res.green_out),
        .o_blue      (o_res.blue_out),
        .o_last      (o_res.last_of_frame),
        .o_empty     (o_res.empty_window)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !status.out_full)
        else $error("result loaded into a full output register");

    a_drop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_res.valid) |-> $past(o_res.ready))
        else $error("result dropped before it was taken");

    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_win |-> $past(cmd.rd_up1))
        else $error("window loaded without the line store reads");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.latch_pix, cmd.rd_up2, cmd.rd_up1, cmd.load_win,
                  cmd.sum, cmd.div_step, cmd.load_out, cmd.advance}))
        else $error("conflicting datapath commands");

endmodule
